### rtl/core/mean_filter_3x3_top_assert.svh
// ----------------------------------------------------------------------------
// mean_filter_3x3_top_assert.svh
// Assertion macros for the box filter, used by mf3_out_q. The enclosing module
// must have clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MEAN_FILTER_3X3_TOP_ASSERT_SVH
`define MEAN_FILTER_3X3_TOP_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define MF3_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define MF3_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### rtl/core/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared widths, constants and types of the 3x3 box filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mf3_pkg;

	localparam int PIX_BITS       = 16;
	localparam int COL_BITS       = 10;
	localparam int ROW_BITS       = 10;
	localparam int CFG_BITS       = 11;
	localparam int CFG_IDX_BITS   = 1;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int RST_WIDTH      = 640;
	localparam int RST_HEIGHT     = 480;

	localparam int WIN_COLS       = 3;
	localparam int SLOTS          = 3;

	// Sum of nine pixels plus rounding bias fits PIX_BITS + 4 bits.
	localparam int COLSUM_BITS    = PIX_BITS + 2;
	localparam int SUM_BITS       = PIX_BITS + 4;
	localparam int PROD_BITS      = 2 * SUM_BITS;
	localparam logic [SUM_BITS-1:0] ROUND_BIAS = SUM_BITS'(4);
	// floor(n / 9) == floor(n * ceil(2^23 / 9) / 2^23) for every n below 2^20
	localparam int DIV_SHIFT      = 23;
	localparam logic [SUM_BITS-1:0] DIV_MULT = SUM_BITS'(932068);

	localparam int OUT_BITS       = PIX_BITS + COL_BITS + ROW_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [PIX_BITS-1:0]    pixel_t;
	typedef pixel_t [2:0]           column_t;   // [0] top, [1] middle, [2] bottom
	typedef logic [COLSUM_BITS-1:0] colsum_t;

	typedef struct packed {
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
		pixel_t              pix;
	} result_t;

	typedef result_t [SLOTS-1:0] bundle_t;
	typedef logic [SLOTS-1:0]    slot_mask_t;

	// Which results an input pixel causes.
	typedef struct packed {
		logic center;    // (x-1, y-1)
		logic right;     // (x, y-1) at the last column
		logic pass;      // (x, y) on the first or last row
		logic interior;  // (x-1, y-1) is filtered, not passed through
	} emit_t;

endpackage

`default_nettype wire

### rtl/core/mf3_cell.sv
// ----------------------------------------------------------------------------
// mf3_cell
// One window column: holds three pixels and their column sum, and hands
// the pixels on to the next older cell on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  mf3_pkg::column_t  col_in,
	output mf3_pkg::column_t  col_q,
	output mf3_pkg::colsum_t  sum_q
);
	import mf3_pkg::*;

	colsum_t col_sum;

	assign col_sum = COLSUM_BITS'(col_in[0]) + COLSUM_BITS'(col_in[1])
		+ COLSUM_BITS'(col_in[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			sum_q <= '0;
		end else if (en) begin
			col_q <= col_in;
			sum_q <= col_sum;
		end
	end

endmodule

`default_nettype wire

### rtl/core/mf3_lines.sv
// ----------------------------------------------------------------------------
// mf3_lines
// Two line stores holding the previous two rows. A pixel goes into store A
// at acceptance; its old A entry passes through rd_a_s1 into store B.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_lines #(
	parameter int DEPTH = mf3_pkg::MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     wr,
	input  logic [$clog2(DEPTH)-1:0] idx,
	input  mf3_pkg::pixel_t          pix,
	output mf3_pkg::pixel_t          line1,
	output mf3_pkg::pixel_t          line2
);
	import mf3_pkg::*;

	localparam int AW = $clog2(DEPTH);

	pixel_t          mem_a [DEPTH];
	pixel_t          mem_b [DEPTH];
	pixel_t          rd_a_s1;
	pixel_t          rd_b_s1;
	pixel_t          byp_d_s1;
	logic            byp_s1;
	logic            v_s1;
	logic [AW-1:0]   idx_s1;

	// Store A: read old entry and write the new pixel at the same edge.
	always_ff @(posedge clk) begin
		if (en) begin
			if (wr) begin
				mem_a[idx] <= pix;
			end
			rd_a_s1 <= mem_a[idx];
		end
	end

	// Store B: takes the old A entry of the item one stage ahead.
	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s1) begin
				mem_b[idx_s1] <= rd_a_s1;
			end
			rd_b_s1 <= mem_b[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1   <= idx;
			byp_d_s1 <= rd_a_s1;
		end
	end

	// Forward the B write that lands at the same edge as this read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			byp_s1 <= 1'b0;
		end else if (en) begin
			v_s1   <= wr;
			byp_s1 <= v_s1 && (idx_s1 == idx);
		end
	end

	assign line1 = rd_a_s1;
	assign line2 = byp_s1 ? byp_d_s1 : rd_b_s1;

endmodule

`default_nettype wire

### rtl/core/mf3_out_q.sv
// ----------------------------------------------------------------------------
// mf3_out_q
// Two-deep queue of result bundles with a serializer that sends one
// result word per handshake, marking the last word of each bundle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mean_filter_3x3_top_assert.svh"

module mf3_out_q (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  mf3_pkg::bundle_t                    in_slots,
	input  mf3_pkg::slot_mask_t                 in_mask,
	output logic                                ready,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mf3_pkg::OUT_TDATA_BITS-1:0]  m_tdata,   // pixel_out, out_col, out_row
	output logic                                m_tlast
);
	import mf3_pkg::*;

	logic       head_v_q;
	logic       tail_v_q;
	slot_mask_t head_mask_q;
	slot_mask_t tail_mask_q;
	bundle_t    head_q;
	bundle_t    tail_q;
	slot_mask_t rest;
	result_t    cur;
	logic       pop;
	logic       head_free;

	assign rest = head_mask_q & (head_mask_q - slot_mask_t'(1));

	always_comb begin
		if (head_mask_q[0]) begin
			cur = head_q[0];
		end else if (head_mask_q[1]) begin
			cur = head_q[1];
		end else begin
			cur = head_q[2];
		end
	end

	assign m_tvalid  = head_v_q;
	assign m_tlast   = (rest == '0);
	assign m_tdata   = OUT_TDATA_BITS'(cur);
	assign pop       = head_v_q && m_tready;
	assign head_free = !head_v_q || (pop && m_tlast);
	assign ready     = !tail_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q    <= 1'b0;
			tail_v_q    <= 1'b0;
			head_mask_q <= '0;
			tail_mask_q <= '0;
		end else if (head_free) begin
			if (tail_v_q) begin
				head_v_q    <= 1'b1;
				head_mask_q <= tail_mask_q;
				tail_v_q    <= push;
				tail_mask_q <= in_mask;
			end else begin
				head_v_q    <= push;
				head_mask_q <= in_mask;
			end
		end else begin
			if (pop) begin
				head_mask_q <= rest;
			end
			if (push) begin
				tail_v_q    <= 1'b1;
				tail_mask_q <= in_mask;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_free) begin
			if (tail_v_q) begin
				head_q <= tail_q;
				tail_q <= in_slots;
			end else begin
				head_q <= in_slots;
			end
		end else if (push) begin
			tail_q <= in_slots;
		end
	end

	`MF3_ASSERT_IMPL(a_tail_behind_head, tail_v_q, head_v_q, "tail bundle without head bundle")
	`MF3_ASSERT_IMPL(a_head_has_word, head_v_q, head_mask_q != '0, "head bundle holds no word")
	`MF3_ASSERT_ALWAYS(a_no_push_when_full, !(push && tail_v_q), "bundle pushed into full queue")

endmodule

`default_nettype wire

### rtl/core/mean_filter_3x3_top.sv
// An accepted pixel passes stage registers s1 to s4 and the output queue before m_tdata.
// Throughput: one pixel per cycle on every row but the last while m_tready stays high, set by
// the window cell chain and the one-read, one-write line stores; from row 2 on, each last-row
// pixel past column 0 causes at least two result words, so s_tready drops there.
// Reset: counters to zero, width 640, height 480, window zero; line stores are not cleared
// and need no clearing pass.
// ----------------------------------------------------------------------------
// mean_filter_3x3_top
// Streaming 3x3 box filter over a raster pixel stream with internal
// column and row tracking; border pixels pass through unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module mean_filter_3x3_top #(
	parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mf3_pkg::PIX_BITS-1:0]        s_tdata,   // pixel_in
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mf3_pkg::OUT_TDATA_BITS-1:0]  m_tdata,   // pixel_out, out_col, out_row
	output logic                                m_tlast,   // last_of_run
	input  logic                                cfg_we,
	input  logic [mf3_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
	input  logic [mf3_pkg::CFG_BITS-1:0]        cfg_wdata
);
	import mf3_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WDW   = $clog2(MAX_WIDTH + 1);
	localparam int HDW   = $clog2(MAX_HEIGHT + 1);
	localparam int WCMP  = (WDW > CFG_BITS) ? WDW : CFG_BITS;
	localparam int HCMP  = (HDW > CFG_BITS) ? HDW : CFG_BITS;
	localparam int W_RST = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
	localparam int H_RST = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;

	// Configuration, stored already clamped to 1..MAX
	logic [WDW-1:0]  w_q;
	logic [HDW-1:0]  h_q;
	logic [WDW-1:0]  w_new;
	logic [HDW-1:0]  h_new;
	logic [WCMP-1:0] w_wr_ext;
	logic [HCMP-1:0] h_wr_ext;

	// Position counters
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [WDW-1:0]  col_p1;
	logic [HDW-1:0]  row_p1;
	logic            last_col;
	logic            last_row;
	emit_t           emit_new;

	logic            adv;
	logic            acc;

	// Pipeline
	logic            v_s1, v_s2, v_s3, v_s4;
	logic [CW-1:0]   x_s1, x_s2, x_s3, x_s4;
	logic [RW-1:0]   y_s1, y_s2, y_s3, y_s4;
	pixel_t          pix_s1, pix_s2, pix_s3, pix_s4;
	emit_t           emit_s1, emit_s2, emit_s3, emit_s4;
	logic [SUM_BITS-1:0]  sum_s3;
	logic [PROD_BITS-1:0] prod_s4;
	pixel_t          c4_s3, c4_s4;
	pixel_t          c5_s3, c5_s4;

	pixel_t          line1;
	pixel_t          line2;
	column_t         chain [WIN_COLS+1];
	colsum_t         csum  [WIN_COLS];
	logic [SUM_BITS-1:0]  total;
	logic [PROD_BITS-1:0] prod;
	pixel_t          mean;

	bundle_t         bundle;
	slot_mask_t      mask;
	logic            push;

	// ---------------- configuration ----------------
	assign w_wr_ext = WCMP'(cfg_wdata);
	assign h_wr_ext = HCMP'(cfg_wdata);
	assign w_new = (cfg_wdata == '0) ? WDW'(1) :
		(w_wr_ext > WCMP'(MAX_WIDTH)) ? WDW'(MAX_WIDTH) : WDW'(cfg_wdata);
	assign h_new = (cfg_wdata == '0) ? HDW'(1) :
		(h_wr_ext > HCMP'(MAX_HEIGHT)) ? HDW'(MAX_HEIGHT) : HDW'(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WDW'(W_RST);
			h_q <= HDW'(H_RST);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_IMAGE_WIDTH:  w_q <= w_new;
				REG_IMAGE_HEIGHT: h_q <= h_new;
				default: ;
			endcase
		end
	end

	// ---------------- acceptance and position ----------------
	assign s_tready = adv;
	assign acc      = s_tvalid && adv;

	assign col_p1   = WDW'(col_q) + WDW'(1);
	assign row_p1   = HDW'(row_q) + HDW'(1);
	assign last_col = (col_p1 >= w_q);
	assign last_row = (row_p1 >= h_q);

	always_comb begin
		emit_new.center   = (row_q >= RW'(2)) && (col_q != '0);
		emit_new.right    = (row_q >= RW'(2)) && last_col;
		emit_new.pass     = (row_q == '0) || last_row;
		emit_new.interior = (col_q >= CW'(2)) && (WDW'(col_q) < w_q) && (HDW'(row_q) < h_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	mf3_lines #(
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.wr     (acc),
		.idx    (col_q),
		.pix    (s_tdata),
		.line1  (line1),
		.line2  (line2)
	);

	// ---------------- window cell chain ----------------
	assign chain[0] = {pix_s1, line1, line2};

	for (genvar i = 0; i < WIN_COLS; i++) begin : g_cell
		mf3_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv && v_s1),
			.col_in (chain[i]),
			.col_q  (chain[i+1]),
			.sum_q  (csum[i])
		);
	end

	assign total = SUM_BITS'(csum[0]) + SUM_BITS'(csum[1]) + SUM_BITS'(csum[2]) + ROUND_BIAS;
	assign prod  = PROD_BITS'(sum_s3) * PROD_BITS'(DIV_MULT);
	assign mean  = prod_s4[DIV_SHIFT +: PIX_BITS];

	// ---------------- pipeline registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= col_q;
			y_s1    <= row_q;
			pix_s1  <= s_tdata;
			emit_s1 <= emit_new;

			x_s2    <= x_s1;
			y_s2    <= y_s1;
			pix_s2  <= pix_s1;
			emit_s2 <= emit_s1;

			x_s3    <= x_s2;
			y_s3    <= y_s2;
			pix_s3  <= pix_s2;
			emit_s3 <= emit_s2;
			sum_s3  <= total;
			c4_s3   <= chain[2][1];
			c5_s3   <= chain[1][1];

			x_s4    <= x_s3;
			y_s4    <= y_s3;
			pix_s4  <= pix_s3;
			emit_s4 <= emit_s3;
			prod_s4 <= prod;
			c4_s4   <= c4_s3;
			c5_s4   <= c5_s3;
		end
	end

	// ---------------- result bundle ----------------
	always_comb begin
		bundle[0].pix = emit_s4.interior ? mean : c4_s4;
		bundle[0].col = COL_BITS'(x_s4 - CW'(1));
		bundle[0].row = ROW_BITS'(y_s4 - RW'(1));
		bundle[1].pix = c5_s4;
		bundle[1].col = COL_BITS'(x_s4);
		bundle[1].row = ROW_BITS'(y_s4 - RW'(1));
		bundle[2].pix = pix_s4;
		bundle[2].col = COL_BITS'(x_s4);
		bundle[2].row = ROW_BITS'(y_s4);
	end

	assign mask = {emit_s4.pass, emit_s4.right, emit_s4.center};
	// drop items that cause no result
	assign push = adv && v_s4 && (mask != '0);

	mf3_out_q u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_slots (bundle),
		.in_mask  (mask),
		.ready    (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

### dv/mean_filter_3x3_top_tb.sv
// ----------------------------------------------------------------------------
// mean_filter_3x3_top_tb
// Self-checking bench for the streaming 3x3 mean filter. A tracker class
// mirrors the line stores, the window and the raster counters. It turns every
// accepted pixel into the words the filter owes and matches them in order
// against m_tdata and m_tlast. Frames run under many width and height
// settings: zero and one-pixel sizes, and dimensions shrunk in the middle of
// a frame. Both stream sides idle at random, and the output side is held off
// once long enough to back the input up.
// ----------------------------------------------------------------------------
module mean_filter_3x3_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mf3_pkg::*;

	localparam int  MAX_DIM  = MAX_WIDTH_DEF;
	localparam real LIMIT_NS = 20_000_000.0;

	typedef struct packed {
		pixel_t              pix;
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
		logic                last;
	} filtered_word_t;

	class mean_window_tracker;
		logic [CFG_BITS-1:0] width_reg;
		logic [CFG_BITS-1:0] height_reg;
		pixel_t              line_a [MAX_DIM];
		pixel_t              line_b [MAX_DIM];
		pixel_t              win [9];     // row-major, column 2 is the newest
		int unsigned         col_cnt;
		int unsigned         row_cnt;
		filtered_word_t      awaited [$];
		int unsigned         mismatches;
		int unsigned         words_checked;

		function new();
			width_reg = CFG_BITS'(RST_WIDTH);
			height_reg = CFG_BITS'(RST_HEIGHT);
			foreach (line_a[i]) begin
				line_a[i] = '0;
				line_b[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			col_cnt = 0;
			row_cnt = 0;
			mismatches = 0;
			words_checked = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_BITS-1:0] value);
			case (idx)
				REG_IMAGE_WIDTH: begin
					width_reg = value;
				end
				REG_IMAGE_HEIGHT: begin
					height_reg = value;
				end
				default: begin
				end
			endcase
		endfunction

		function filtered_word_t make_word(pixel_t p, int unsigned c, int unsigned r);
			filtered_word_t wd;
			wd.pix = p;
			wd.col = COL_BITS'(c);
			wd.row = ROW_BITS'(r);
			wd.last = 1'b0;
			return wd;
		endfunction

		function void take_pixel(pixel_t pix);
			int unsigned    w, h, x, y, cx, cy, sum, idx, n;
			bit             last_col, last_row;
			pixel_t         centre;
			filtered_word_t made [3];
			// zero counts as one, anything past the store depth saturates
			w = (width_reg == 0) ? 1 : (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
			h = (height_reg == 0) ? 1 : (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
			x = col_cnt;
			y = row_cnt;
			idx = x % MAX_DIM;
			last_col = (x + 1 >= w);
			last_row = (y + 1 >= h);
			n = 0;
			for (int r = 0; r < 3; r++) begin
				win[r*3] = win[r*3+1];
				win[r*3+1] = win[r*3+2];
			end
			win[2] = line_b[idx];
			win[5] = line_a[idx];
			win[8] = pix;
			line_b[idx] = line_a[idx];
			line_a[idx] = pix;
			if (y >= 2) begin
				cy = y - 1;
				if (x >= 1) begin
					cx = x - 1;
					centre = win[4];
					if (cx >= 1 && cx + 1 < w && cy + 1 < h) begin
						sum = 4;
						foreach (win[i]) sum += win[i];
						centre = pixel_t'(sum / 9);
					end
					made[n] = make_word(centre, cx, cy);
					n++;
				end
				if (last_col) begin
					made[n] = make_word(win[5], x, cy);
					n++;
				end
			end
			if (y == 0 || last_row) begin
				made[n] = make_word(pix, x, y);
				n++;
			end
			if (n > 0) made[n-1].last = 1'b1;
			for (int i = 0; i < n; i++) awaited.push_back(made[i]);
			if (last_col) begin
				col_cnt = 0;
				row_cnt = last_row ? 0 : y + 1;
			end else begin
				col_cnt = x + 1;
			end
		endfunction

		function void check_result(logic [OUT_TDATA_BITS-1:0] data, logic last);
			result_t        fields;
			filtered_word_t got, want;
			fields = result_t'(data[OUT_BITS-1:0]);
			got.pix = fields.pix;
			got.col = fields.col;
			got.row = fields.row;
			got.last = last;
			words_checked++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: pix %0d col %0d row %0d last %0b",
						got.pix, got.col, got.row, got.last);
				return;
			end
			want = awaited.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected pix %0d col %0d row %0d last %0b",
						want.pix, want.col, want.row, want.last);
					$display("          got      pix %0d col %0d row %0d last %0b",
						got.pix, got.col, got.row, got.last);
				end
			end
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	pixel_t                    s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_tdata;
	logic                      m_tlast;
	logic                      cfg_we = 1'b0;
	cfg_reg_t                  cfg_idx = REG_IMAGE_WIDTH;
	logic [CFG_BITS-1:0]       cfg_wdata = '0;

	mean_window_tracker tracker = new();

	int unsigned pixels_sent = 0;
	int unsigned settings_used = 0;
	int unsigned tready_hold = 0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;
	bit          src_idle = 1'b0;
	bit          snk_idle = 1'b0;
	bit          calm = 1'b0;

	pixel_t corner_frame [16] = '{
		16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
		16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001,
		16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000,
		16'h0000, 16'h0005, 16'h7FFF, 16'hFFFF
	};

	mean_filter_3x3_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	// Output side: a long hold when asked, otherwise short random stalls while snk_idle is set.
	always @(negedge clk) begin
		if (tready_hold != 0) begin
			hold_left = tready_hold;
			tready_hold = 0;
		end
		if (hold_left != 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else if (stall_left != 0) begin
			m_tready = 1'b0;
			stall_left--;
		end else if (snk_idle && $urandom_range(0, 4) == 0) begin
			m_tready = 1'b0;
			stall_left = $urandom_range(0, 5);
		end else begin
			m_tready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tlast);
	end

	function automatic pixel_t next_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return pixel_t'(16'hFFF0 + $urandom_range(0, 15));
			default: return pixel_t'($urandom);
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_pixel(input pixel_t pix);
		if (src_idle && $urandom_range(0, 3) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = pix;
		do @(posedge clk); while (!s_tready);
		tracker.take_pixel(pix);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic feed_frame();
		do send_pixel(next_pixel()); while (tracker.col_cnt != 0 || tracker.row_cnt != 0);
	endtask

	// Drop valid, wait for every owed word, then cover the pipeline latency.
	task automatic settle();
		s_tvalid = 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = CFG_BITS'(value);
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.set_reg(idx, CFG_BITS'(value));
	endtask

	task automatic set_dims(input int unsigned w, input int unsigned h);
		settle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		settings_used++;
		if (!calm) begin
			src_idle = $urandom_range(0, 2) != 0;
			snk_idle = $urandom_range(0, 2) != 0;
		end
	endtask

	initial begin
		int unsigned rand_start, w, h;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// saturated windows, rounding and the small frame shapes
		set_dims(4, 4);
		foreach (corner_frame[i]) send_pixel(corner_frame[i]);
		set_dims(0, 5);
		feed_frame();
		set_dims(3, 0);
		feed_frame();
		set_dims(2, 2);
		feed_frame();

		// shrink width, then height, in the middle of a frame
		set_dims(12, 8);
		repeat (43) send_pixel(next_pixel());
		settle();
		write_reg(REG_IMAGE_WIDTH, 5);
		repeat (6) send_pixel(next_pixel());
		settle();
		write_reg(REG_IMAGE_HEIGHT, 3);
		feed_frame();

		rand_start = pixels_sent;
		set_dims(16, 6);
		tready_hold = 200;
		feed_frame();
		while (pixels_sent - rand_start < 260) begin
			if (pixels_sent - rand_start >= 200) calm = 1'b1;
			if ($urandom_range(0, 4) == 0) begin
				w = $urandom_range(1, 32);
				h = $urandom_range(1, 4);
			end else begin
				w = $urandom_range(1, 16);
				h = $urandom_range(1, 8);
			end
			set_dims(w, h);
			if (calm) begin
				src_idle = 1'b0;
				snk_idle = 1'b0;
			end
			repeat ($urandom_range(1, 2)) feed_frame();
		end

		s_tvalid = 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d pixels (%0d random) under %0d dimension settings",
			pixels_sent, pixels_sent - rand_start, settings_used);
		$display("checked %0d result words, %0d mismatched, %0d still owed",
			tracker.words_checked, tracker.mismatches, tracker.pending());
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("mean_filter_3x3_top regression: pass");
		end else begin
			$display("mean_filter_3x3_top regression: fail");
		end
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("timeout with %0d words still owed", tracker.pending());
		$display("mean_filter_3x3_top regression: fail");
		$finish;
	end

endmodule
